FILE: hdl/frr_pkg.sv
// Shared types and constants for the frame rate fraction reducer.
// No dependencies; every other file in hdl/ imports this package.
package frr_pkg;

    localparam int FRR_FRACTION_BITS = 16;
    localparam int FRR_IN_W          = 16;
    localparam int FRR_SRC_W         = 16;
    localparam int FRR_MIN_W         = 8;
    localparam int FRR_RES_W         = 32;
    localparam int FRR_CFG_IDX_W     = 2;

    localparam logic [FRR_SRC_W-1:0] FRR_SRC_NUM_RST = 16'd30;
    localparam logic [FRR_SRC_W-1:0] FRR_SRC_DEN_RST = 16'd1;
    localparam logic [FRR_MIN_W-1:0] FRR_MIN_FPS_RST = 8'd23;

    typedef enum logic [FRR_CFG_IDX_W-1:0] {
        FRR_REG_SRC_NUM = 2'd0,
        FRR_REG_SRC_DEN = 2'd1,
        FRR_REG_MIN_FPS = 2'd2
    } t_frr_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_BAD,
        S_MUL,
        S_LIMIT,
        S_DECIDE,
        S_GCD,
        S_DIVN_LOAD,
        S_DIVN,
        S_DIVD_LOAD,
        S_DIVD,
        S_OUT
    } t_frr_state;

    typedef struct packed {
        logic capture;
        logic multiply;
        logic limit;
        logic decide;
        logic gcd_step;
        logic div_load;
        logic div_sel;      // 0 selects the numerator, 1 the denominator
        logic div_step;
        logic save_num;
        logic out_load;
        logic out_bad;
    } t_frr_cmd;

    typedef struct packed {
        logic bad;
        logic gcd_done;
        logic div_done;
    } t_frr_stat;

endpackage

FILE: hdl/frr_if.sv
// Channel interfaces for the frame rate fraction reducer: input, result and
// configuration. Depends on frr_pkg.
interface frr_in_if import frr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FRR_IN_W-1:0] fraction_numerator;
    logic [FRR_IN_W-1:0] fraction_denominator;
    logic                apply_floor;

    modport source (output valid, fraction_numerator, fraction_denominator, apply_floor,
                    input ready);
    modport sink   (input valid, fraction_numerator, fraction_denominator, apply_floor,
                    output ready);
endinterface

interface frr_out_if import frr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FRR_RES_W-1:0] result_numerator;
    logic [FRR_RES_W-1:0] result_denominator;
    logic                 reverted;
    logic                 bad_input;

    modport source (output valid, result_numerator, result_denominator, reverted, bad_input,
                    input ready);
    modport sink   (input valid, result_numerator, result_denominator, reverted, bad_input,
                    output ready);
endinterface

interface frr_cfg_if import frr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FRR_CFG_IDX_W-1:0] index;
    logic [FRR_SRC_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/frr_ctrl.sv
// Sequencing state machine for the frame rate fraction reducer.
// Depends on frr_pkg; drives frr_dp through t_frr_cmd and reads t_frr_stat.
module frr_ctrl import frr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_frr_stat i_stat,
    output t_frr_cmd  o_cmd
);

    t_frr_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.bad ? S_BAD : S_MUL;
            end
            S_BAD: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_bad  = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.multiply = 1'b1;
                n_state        = S_LIMIT;
            end
            S_LIMIT: begin
                o_cmd.limit = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = S_DIVN_LOAD;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = 1'b0;
                n_state        = S_DIVN;
            end
            S_DIVN: begin
                if (i_stat.div_done) begin
                    o_cmd.save_num = 1'b1;
                    n_state        = S_DIVD_LOAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVD_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = 1'b1;
                n_state        = S_DIVD;
            end
            S_DIVD: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A new result only appears from one of the two delivery states.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT || $past(r_state) == S_BAD))
        else $error("result appeared outside a delivery state");

    // The result register is never overwritten while a result is still pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> w_out_free)
        else $error("result register loaded while occupied");

    // A bad transaction never reaches the arithmetic sequence.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_stat.bad) |=> r_state == S_BAD)
        else $error("bad input entered the arithmetic path");

endmodule

FILE: hdl/frr_dp.sv
// Datapath of the frame rate fraction reducer: configuration registers,
// products, floor test, binary gcd, shared restoring divider, result register.
// Depends on frr_pkg and frr_if; controlled by frr_ctrl.
module frr_dp import frr_pkg::*; #(
    parameter int FRACTION_BITS = FRR_FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frr_cfg_if.sink              i_cfg,
    input  logic [FRR_IN_W-1:0]  i_fraction_numerator,
    input  logic [FRR_IN_W-1:0]  i_fraction_denominator,
    input  logic                 i_apply_floor,
    input  t_frr_cmd             i_cmd,
    output t_frr_stat            o_stat,
    output logic [FRR_RES_W-1:0] o_result_numerator,
    output logic [FRR_RES_W-1:0] o_result_denominator,
    output logic                 o_reverted,
    output logic                 o_bad_input
);

    localparam int EFF_BITS = (FRACTION_BITS < FRR_IN_W) ? FRACTION_BITS : FRR_IN_W;
    localparam int PROD_W   = EFF_BITS + FRR_SRC_W;
    localparam int LIM_W    = PROD_W + FRR_MIN_W;
    localparam int KW       = $clog2(PROD_W + 1);

    logic [FRR_SRC_W-1:0] r_src_num, r_src_den;
    logic [FRR_MIN_W-1:0] r_min_fps;

    logic [EFF_BITS-1:0]  r_fn, r_fd;
    logic                 r_floor, r_reduces, r_rev;
    logic [PROD_W-1:0]    r_pn, r_pd;
    logic [LIM_W-1:0]     r_lim;
    logic [PROD_W-1:0]    r_ga, r_gb;
    logic [KW-1:0]        r_gk;
    logic [PROD_W-1:0]    r_dv_q, r_dv_rem, r_dv_d, r_qn;
    logic [KW-1:0]        r_dv_cnt;

    logic [FRR_RES_W-1:0] r_out_num, r_out_den;
    logic                 r_out_rev, r_out_bad;

    logic                 w_rev;
    logic [PROD_W-1:0]    w_pn_sel, w_pd_sel, w_gcd;
    logic [PROD_W:0]      w_rem_sh, w_diff;
    logic [FRR_MIN_W-1:0] w_minv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_num <= FRR_SRC_NUM_RST;
            r_src_den <= FRR_SRC_DEN_RST;
            r_min_fps <= FRR_MIN_FPS_RST;
        end else if (i_cfg.valid) begin
            unique case (t_frr_reg'(i_cfg.index))
                FRR_REG_SRC_NUM: r_src_num <= i_cfg.data;
                FRR_REG_SRC_DEN: r_src_den <= i_cfg.data;
                FRR_REG_MIN_FPS: r_min_fps <= i_cfg.data[FRR_MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stat.bad      = (r_fd == '0) || (r_src_den == '0);
    assign o_stat.gcd_done = (r_ga == '0) || (r_gb == '0);
    assign o_stat.div_done = (r_dv_cnt == '0);

    assign w_minv   = r_floor ? r_min_fps : '0;
    // Comparing against minimum times denominator is the same as comparing
    // the whole quotient against the minimum.
    assign w_rev    = r_reduces && (LIM_W'(r_pn) < r_lim);
    assign w_pn_sel = w_rev ? PROD_W'(r_src_num) : r_pn;
    assign w_pd_sel = w_rev ? PROD_W'(r_src_den) : r_pd;

    // One of the two terms is zero once the loop ends; the other carries the
    // odd part of the divisor and the shared powers of two go back on.
    assign w_gcd    = (r_ga | r_gb) << r_gk;

    assign w_rem_sh = {r_dv_rem, r_dv_q[PROD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dv_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_fn    <= i_fraction_numerator[EFF_BITS-1:0];
            r_fd    <= i_fraction_denominator[EFF_BITS-1:0];
            r_floor <= i_apply_floor;
        end
        if (i_cmd.multiply) begin
            r_pn      <= PROD_W'(r_fn) * PROD_W'(r_src_num);
            r_pd      <= PROD_W'(r_fd) * PROD_W'(r_src_den);
            r_reduces <= r_fn < r_fd;
        end
        if (i_cmd.limit) begin
            r_lim <= LIM_W'(w_minv) * LIM_W'(r_pd);
        end
        if (i_cmd.decide) begin
            r_pn  <= w_pn_sel;
            r_pd  <= w_pd_sel;
            r_ga  <= w_pn_sel;
            r_gb  <= w_pd_sel;
            r_gk  <= '0;
            r_rev <= w_rev;
        end
        if (i_cmd.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_gk <= r_gk + KW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_load) begin
            r_dv_q   <= i_cmd.div_sel ? r_pd : r_pn;
            r_dv_rem <= '0;
            r_dv_d   <= w_gcd;
            r_dv_cnt <= KW'(PROD_W);
        end
        if (i_cmd.div_step) begin
            if (!w_diff[PROD_W]) begin
                r_dv_rem <= w_diff[PROD_W-1:0];
                r_dv_q   <= {r_dv_q[PROD_W-2:0], 1'b1};
            end else begin
                r_dv_rem <= w_rem_sh[PROD_W-1:0];
                r_dv_q   <= {r_dv_q[PROD_W-2:0], 1'b0};
            end
            r_dv_cnt <= r_dv_cnt - KW'(1);
        end
        if (i_cmd.save_num) begin
            r_qn <= r_dv_q;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_bad) begin
                r_out_num <= '0;
                r_out_den <= '0;
                r_out_rev <= 1'b0;
                r_out_bad <= 1'b1;
            end else begin
                r_out_num <= FRR_RES_W'(r_qn);
                r_out_den <= FRR_RES_W'(r_dv_q);
                r_out_rev <= r_rev;
                r_out_bad <= 1'b0;
            end
        end
    end

    assign o_result_numerator   = r_out_num;
    assign o_result_denominator = r_out_den;
    assign o_reverted           = r_out_rev;
    assign o_bad_input          = r_out_bad;

    // The divisor handed to the divider comes from a nonzero denominator.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> w_gcd != '0)
        else $error("zero divisor loaded into the divider");

    // The gcd divides both terms exactly.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.save_num || (i_cmd.out_load && !i_cmd.out_bad)) |-> r_dv_rem == '0)
        else $error("reduction left a remainder");

    // A valid reduced denominator is never zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !i_cmd.out_bad) |-> r_dv_q != '0)
        else $error("zero denominator in a good result");

endmodule

FILE: hdl/frame_rate_fraction_reducer.sv
// Top level of the frame rate fraction reducer: joins frr_ctrl and frr_dp.
// Depends on frr_pkg, frr_if, frr_ctrl and frr_dp.
//
//  channel   dir   handshake             payload
//  i_in      in    valid / ready         fraction_numerator, fraction_denominator,
//                                        apply_floor
//  o_out     out   valid / ready         result_numerator, result_denominator,
//                                        reverted, bad_input
//  i_cfg     in    valid / ready (=1)    index, data
//
// One transaction at a time. A bad denominator goes from the check straight to the
// output; otherwise the products, floor test, binary gcd loop and two divisions on
// PROD_W-bit values run in turn, where PROD_W = min(FRACTION_BITS,16) + 16. The binary
// gcd loop and the shared one-bit-a-cycle divider take most of the time.
// Reset is synchronous and active low; configuration returns to 30/1 fps, minimum 23.
// A finished result waits in the output register while the next transaction is
// accepted; the block stalls only when a second result is ready before the first
// has been taken.
module frame_rate_fraction_reducer import frr_pkg::*; #(
    parameter int FRACTION_BITS = FRR_FRACTION_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frr_in_if.sink     i_in,
    frr_out_if.source  o_out,
    frr_cfg_if.sink    i_cfg
);

    t_frr_cmd  w_cmd;
    t_frr_stat w_stat;

    frr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    frr_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg                  (i_cfg),
        .i_fraction_numerator   (i_in.fraction_numerator),
        .i_fraction_denominator (i_in.fraction_denominator),
        .i_apply_floor          (i_in.apply_floor),
        .i_cmd                  (w_cmd),
        .o_stat                 (w_stat),
        .o_result_numerator     (o_out.result_numerator),
        .o_result_denominator   (o_out.result_denominator),
        .o_reverted             (o_out.reverted),
        .o_bad_input            (o_out.bad_input)
    );

endmodule

FILE: bench/frame_rate_fraction_reducer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_rate_fraction_reducer: a directed table, then random phases.
// Depends on frr_pkg, the channel interfaces in frr_if and the block's top level.
module frame_rate_fraction_reducer_tb;
    import frr_pkg::*;

    localparam logic [FRR_CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_MAX        = 17;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_REQUESTS  = 250;
    localparam int SETTLE_CYCLES   = 300;

    typedef struct packed {
        logic [FRR_IN_W-1:0] num;
        logic [FRR_IN_W-1:0] den;
        logic                apply_floor;
    } t_rate_request;

    typedef struct packed {
        logic [FRR_RES_W-1:0] num;
        logic [FRR_RES_W-1:0] den;
        logic                 reverted;
        logic                 bad_input;
    } t_frame_rate;

    typedef enum bit {ROW_FRACTION, ROW_SETUP} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_rate_request        req;
        logic [FRR_SRC_W-1:0] src_num;
        logic [FRR_SRC_W-1:0] src_den;
        logic [FRR_SRC_W-1:0] min_data;
        logic                 typed;
        t_frame_rate          rate;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frr_in_if  fraction_if ();
    frr_out_if rate_if ();
    frr_cfg_if cfg_if ();

    frame_rate_fraction_reducer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (fraction_if),
        .o_out   (rate_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // Copy of the block's registers, updated as each register transaction is accepted.
    logic [FRR_SRC_W-1:0] src_rate_num = FRR_SRC_NUM_RST;
    logic [FRR_SRC_W-1:0] src_rate_den = FRR_SRC_DEN_RST;
    logic [FRR_MIN_W-1:0] min_fps      = FRR_MIN_FPS_RST;

    t_frame_rate   expected_rates[$];
    t_directed_row directed_rows[$];

    bit no_idle = 1'b0;
    int in_gap = 1;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int reverts_seen = 0;
    int bad_seen = 0;
    int setups_done = 0;

    function automatic t_frame_rate reduce_rate(input t_rate_request req);
        logic [63:0] prod_num, prod_den, a, b, t, floor_val;
        logic        below_one;
        t_frame_rate rate;
        rate = '0;
        if (req.den == '0 || src_rate_den == '0) begin
            rate.bad_input = 1'b1;
            return rate;
        end
        below_one = req.num < req.den;
        prod_num  = 64'(req.num) * 64'(src_rate_num);
        prod_den  = 64'(req.den) * 64'(src_rate_den);
        floor_val = req.apply_floor ? 64'(min_fps) : 64'd0;
        if (below_one && (prod_num / prod_den) < floor_val) begin
            prod_num = 64'(src_rate_num);
            prod_den = 64'(src_rate_den);
            rate.reverted = 1'b1;
        end
        a = prod_num;
        b = prod_den;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        rate.num = FRR_RES_W'(prod_num / a);
        rate.den = FRR_RES_W'(prod_den / a);
        return rate;
    endfunction

    function automatic t_directed_row fraction_row(input logic [15:0] n, d, input logic fl);
        t_directed_row row;
        row = '0;
        row.kind = ROW_FRACTION;
        row.req  = '{n, d, fl};
        return row;
    endfunction

    function automatic t_directed_row checked_row(input logic [15:0] n, d, input logic fl,
                                                  input logic [31:0] rn, rd,
                                                  input logic rev, bad);
        t_directed_row row;
        row = fraction_row(n, d, fl);
        row.typed = 1'b1;
        row.rate  = '{rn, rd, rev, bad};
        return row;
    endfunction

    function automatic t_directed_row setup_row(input logic [15:0] sn, sd, mn);
        t_directed_row row;
        row = '0;
        row.kind     = ROW_SETUP;
        row.src_num  = sn;
        row.src_den  = sd;
        row.min_data = mn;
        return row;
    endfunction

    function automatic int draw_idle();
        return no_idle ? 0 : int'($urandom_range(0, IDLE_MAX));
    endfunction

    function automatic t_rate_request random_request();
        t_rate_request req;
        int unsigned   scale;
        req.apply_floor = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: begin
                req.num = 16'($urandom);
                req.den = '0;
            end
            1: begin
                req.num = '0;
                req.den = 16'($urandom_range(1, 65535));
            end
            2, 3, 4: begin
                req.num = 16'($urandom);
                req.den = 16'($urandom);
            end
            5, 6: begin
                req.num = 16'($urandom_range(1, 64));
                req.den = 16'($urandom_range(1, 64));
            end
            7, 8: begin
                // Below one, so the floor test decides the outcome.
                req.den = 16'($urandom_range(1, 65535));
                req.num = 16'($urandom_range(0, int'(req.den) - 1));
            end
            default: begin
                // A shared factor gives the reduction something to remove.
                scale   = $urandom_range(1, 255);
                req.num = 16'(scale * $urandom_range(1, 255));
                req.den = 16'(scale * $urandom_range(1, 255));
            end
        endcase
        return req;
    endfunction

    function automatic void compare_field(input string field,
                                          input logic [FRR_RES_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(input t_rate_request req, input logic typed,
                                input t_frame_rate typed_rate);
        if (in_gap > 0) begin
            // Sometimes the gap starts only once the block is ready again.
            if ($urandom_range(0, 1) == 1)
                while (!fraction_if.ready) @(posedge i_clk);
            repeat (in_gap) @(posedge i_clk);
        end
        fraction_if.valid                <= 1'b1;
        fraction_if.fraction_numerator   <= req.num;
        fraction_if.fraction_denominator <= req.den;
        fraction_if.apply_floor          <= req.apply_floor;
        do @(posedge i_clk); while (!fraction_if.ready);
        expected_rates.push_back(typed ? typed_rate : reduce_rate(req));
        requests_sent++;
        // With no gap, valid stays high so the next transaction follows at once.
        in_gap = draw_idle();
        if (in_gap > 0)
            fraction_if.valid <= 1'b0;
    endtask

    task automatic drain_results;
        if (in_gap == 0) begin
            fraction_if.valid <= 1'b0;
            in_gap = 1;
        end
        while (expected_rates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [FRR_CFG_IDX_W-1:0] index,
                             input logic [FRR_SRC_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (index)
            FRR_REG_SRC_NUM: src_rate_num = data;
            FRR_REG_SRC_DEN: src_rate_den = data;
            FRR_REG_MIN_FPS: min_fps      = data[FRR_MIN_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with nothing in flight; the spare index must leave the setup unchanged.
    task automatic set_config(input logic [FRR_SRC_W-1:0] sn, sd, mn);
        write_reg(FRR_REG_SRC_NUM, sn);
        write_reg(FRR_REG_SRC_DEN, sd);
        write_reg(FRR_REG_MIN_FPS, mn);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_if.valid <= 1'b0;
        setups_done++;
    endtask

    task automatic random_setup;
        logic [FRR_SRC_W-1:0] sn, sd;
        case ($urandom_range(0, 3))
            0: begin
                if ($urandom_range(0, 1) == 1) begin
                    sn = 16'($urandom_range(12, 120));
                    sd = 16'd1;
                end else begin
                    sn = 16'(1000 * $urandom_range(12, 60));
                    sd = 16'd1001;
                end
            end
            1: begin
                sn = 16'($urandom_range(1, 65535));
                sd = 16'($urandom_range(1, 65535));
            end
            2: begin
                sn = ($urandom_range(0, 1) == 1) ? 16'd65535 : 16'd1;
                sd = ($urandom_range(0, 1) == 1) ? 16'd65535 : 16'd1;
            end
            default: begin
                sn = 16'($urandom_range(1, 100));
                sd = 16'($urandom_range(1, 100));
            end
        endcase
        set_config(sn, sd, 16'($urandom));
    endtask

    initial begin : result_monitor
        t_frame_rate got, want;
        int          stall;
        rate_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_idle();
            if (stall == 0) begin
                rate_if.ready <= 1'b1;
            end else begin
                rate_if.ready <= 1'b0;
                do @(posedge i_clk); while (!rate_if.valid);
                repeat (stall - 1) @(posedge i_clk);
                rate_if.ready <= 1'b1;
            end
            do @(posedge i_clk); while (!rate_if.valid);
            got = '{rate_if.result_numerator, rate_if.result_denominator,
                    rate_if.reverted, rate_if.bad_input};
            results_checked++;
            reverts_seen += got.reverted;
            bad_seen     += got.bad_input;
            if (expected_rates.size() == 0) begin
                $error("result transaction arrived with no request outstanding");
                mismatches++;
            end else begin
                want = expected_rates.pop_front();
                compare_field("result_numerator", want.num, got.num);
                compare_field("result_denominator", want.den, got.den);
                compare_field("reverted", 32'(want.reverted), 32'(got.reverted));
                compare_field("bad_input", 32'(want.bad_input), 32'(got.bad_input));
            end
        end
    end

    initial begin : stimulus
        fraction_if.valid                = 1'b0;
        fraction_if.fraction_numerator   = '0;
        fraction_if.fraction_denominator = '0;
        fraction_if.apply_floor          = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = FRR_REG_SRC_NUM;
        cfg_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rows up to the first setup run with the reset values: 30/1 fps, minimum 23.
        directed_rows = '{
            checked_row(16'd1, 16'd1, 1'b1, 32'd30, 32'd1, 1'b0, 1'b0),
            checked_row(16'd0, 16'd1, 1'b0, 32'd0, 32'd1, 1'b0, 1'b0),
            checked_row(16'd0, 16'd1, 1'b1, 32'd30, 32'd1, 1'b1, 1'b0),
            checked_row(16'd5, 16'd0, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
            checked_row(16'd0, 16'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1),
            checked_row(16'd65535, 16'd0, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
            checked_row(16'd65535, 16'd65535, 1'b1, 32'd30, 32'd1, 1'b0, 1'b0),
            checked_row(16'd65535, 16'd1, 1'b0, 32'd1966050, 32'd1, 1'b0, 1'b0),
            fraction_row(16'd1, 16'd65535, 1'b0),
            checked_row(16'd1, 16'd65535, 1'b1, 32'd30, 32'd1, 1'b1, 1'b0),
            fraction_row(16'd1, 16'd2, 1'b0),
            checked_row(16'd1, 16'd2, 1'b1, 32'd30, 32'd1, 1'b1, 1'b0),
            fraction_row(16'd4, 16'd5, 1'b1),
            fraction_row(16'd23, 16'd30, 1'b1),
            fraction_row(16'd22, 16'd29, 1'b1),
            fraction_row(16'd1000, 16'd1001, 1'b1),
            fraction_row(16'hAAAA, 16'h5555, 1'b0),
            fraction_row(16'h5555, 16'hAAAA, 1'b1),
            setup_row(16'd65535, 16'd65535, 16'hFFFF),
            checked_row(16'd65535, 16'd65535, 1'b1, 32'd1, 32'd1, 1'b0, 1'b0),
            fraction_row(16'd1, 16'd2, 1'b1),
            fraction_row(16'd65535, 16'd1, 1'b0),
            setup_row(16'd65535, 16'd1, 16'hFF00),
            fraction_row(16'd65535, 16'd1, 1'b1),
            fraction_row(16'd0, 16'd5, 1'b1),
            // A zero source denominator turns every request into an error.
            setup_row(16'd7, 16'd0, 16'd23),
            checked_row(16'd3, 16'd7, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
            checked_row(16'd0, 16'd1, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1)
        };

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETUP) begin
                drain_results();
                set_config(directed_rows[i].src_num, directed_rows[i].src_den,
                           directed_rows[i].min_data);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].rate);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            if (phase == 0)
                set_config(FRR_SRC_NUM_RST, FRR_SRC_DEN_RST, 16'(FRR_MIN_FPS_RST));
            else
                random_setup();
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (PHASE_REQUESTS) send_request(random_request(), 1'b0, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results over %0d register setups.",
                 requests_sent, results_checked, setups_done);
        $display("%0d results fell back to the source rate, %0d flagged a zero denominator.",
                 reverts_seen, bad_seen);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Ends a hung run with an error.
    initial begin : watchdog
        #20ms;
        $error("timeout with %0d results still outstanding", expected_rates.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/frr_pkg.sv
hdl/frr_if.sv
hdl/frr_ctrl.sv
hdl/frr_dp.sv
hdl/frame_rate_fraction_reducer.sv
bench/frame_rate_fraction_reducer_tb.sv
